// File: hw/rtl/olt_pkg.sv
// ----------------------------------------------------------------------------
// olt_pkg
// Shared types and constants for the ordered list table engine.
// ----------------------------------------------------------------------------
package olt_pkg;

   localparam int DEPTH_DEFAULT = 64;

   localparam int OP_W     = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 6;
   localparam int STATUS_W = 2;
   localparam int TOTAL_W  = 7;
   localparam int LIMIT_W  = 7;

   localparam logic [LIMIT_W-1:0] SIZE_LIMIT_RESET = 7'd64;

   localparam logic [OP_W-1:0] OP_APPEND       = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE_VALUE = 3'd1;
   localparam logic [OP_W-1:0] OP_INSERT_AT    = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE_AT    = 3'd3;
   localparam logic [OP_W-1:0] OP_READ_AT      = 3'd4;
   localparam logic [OP_W-1:0] OP_FIND         = 3'd5;

   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_BAD_POS   = 2'd3;

   typedef enum logic [1:0] {
      MODE_HOLD,
      MODE_OPEN,
      MODE_CLOSE_POS,
      MODE_CLOSE_MATCH
   } mode_type;

   typedef struct packed {
      logic     cmp_en;
      logic     upd_en;
      mode_type mode;
   } cell_ctrl_type;

   typedef enum logic {
      S_IDLE,
      S_UPDATE
   } state_type;

endpackage

// File: hw/rtl/olt_if.sv
// ----------------------------------------------------------------------------
// olt_if
// Channel interfaces: request, response and size limit write.
// ----------------------------------------------------------------------------
interface olt_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         operation;
   logic signed [31:0] value;
   logic [5:0]         position;

   modport source (output valid, operation, value, position, input ready);
   modport sink   (input valid, operation, value, position, output ready);
endinterface

interface olt_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] read_value;
   logic [5:0]         found_position;
   logic [6:0]         entry_total;

   modport source (output valid, status, read_value, found_position, entry_total,
                   input ready);
   modport sink   (input valid, status, read_value, found_position, entry_total,
                   output ready);
endinterface

interface olt_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] size_limit;

   modport source (output valid, size_limit, input ready);
   modport sink   (input valid, size_limit, output ready);
endinterface

// File: hw/rtl/olt_cell.sv
// ----------------------------------------------------------------------------
// olt_cell
// One list slot: holds an entry, compares it against the broadcast value and
// shifts with its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module olt_cell
   import olt_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CNT_W = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  cell_ctrl_type       ctrl,
   input  logic [VALUE_W-1:0]  cmp_value,
   input  logic [VALUE_W-1:0]  wr_value,
   input  logic [CNT_W-1:0]    pos,
   input  logic [CNT_W-1:0]    count,
   input  logic [VALUE_W-1:0]  left_data,
   input  logic [VALUE_W-1:0]  right_data,
   input  logic                chain_in,
   output logic                chain_out,
   output logic [VALUE_W-1:0]  data_out,
   output logic [VALUE_W-1:0]  read_tap,
   output logic [POS_W-1:0]    found_tap
);

   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

   logic [VALUE_W-1:0] data_ff;
   logic [VALUE_W-1:0] data_in;
   logic               match_ff;
   logic               match_in;

   assign chain_out = chain_in | match_ff;
   assign data_out  = data_ff;
   assign read_tap  = (MY_IDX == pos) ? data_ff : '0;
   assign found_tap = (match_ff && !chain_in) ? POS_W'(INDEX) : '0;

   always_comb begin
      match_in = match_ff;
      if (ctrl.cmp_en) begin
         match_in = (data_ff == cmp_value) && (MY_IDX < count);
      end
   end

   always_comb begin
      data_in = data_ff;
      if (ctrl.upd_en) begin
         case (ctrl.mode)
            MODE_OPEN: begin
               if (MY_IDX > pos) begin
                  data_in = left_data;
               end else if (MY_IDX == pos) begin
                  data_in = wr_value;
               end
            end
            MODE_CLOSE_POS: begin
               if (MY_IDX >= pos) begin
                  data_in = right_data;
               end
            end
            MODE_CLOSE_MATCH: begin
               if (chain_out) begin
                  data_in = right_data;
               end
            end
            default: begin
               data_in = data_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

endmodule

// File: hw/rtl/ordered_list_table_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_table_engine
// Dense ordered list of signed 32-bit entries in a row of slot cells.
// ----------------------------------------------------------------------------
// Response: registered in the update state, after the request has been accepted.
// Requests: compare on acceptance, then shift in the update state, one at a time.
// A pending response holds the shift cycle, and the next request waits behind it.
// Reset: entry count cleared, size limit 64; slot contents left undefined.
// ----------------------------------------------------------------------------
module ordered_list_table_engine
   import olt_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   olt_req_if.sink    req_if,
   olt_rsp_if.source  rsp_if,
   olt_csr_if.sink    csr_if
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   state_type state_ff;
   state_type state_in;

   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic [LIMIT_W-1:0]  limit_ff;
   logic [OP_W-1:0]     op_ff;
   logic [VALUE_W-1:0]  value_ff;
   logic [POS_W-1:0]    pos_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [VALUE_W-1:0]  read_ff;
   logic [POS_W-1:0]    found_ff;

   logic                req_fire;
   logic                upd_fire;
   logic                out_free;

   logic [STATUS_W-1:0] status_in;
   logic [VALUE_W-1:0]  read_in;
   logic [POS_W-1:0]    found_in;
   mode_type            mode;
   logic [CNT_W-1:0]    cell_pos;
   cell_ctrl_type       cell_ctrl;

   logic [CMP_W-1:0]    cnt_ext;
   logic [CMP_W-1:0]    pos_ext;
   logic                is_full;
   logic                found;

   logic [VALUE_W-1:0]  cell_data [DEPTH];
   logic [VALUE_W-1:0]  read_tap  [DEPTH];
   logic [POS_W-1:0]    found_tap [DEPTH];
   logic [DEPTH:0]      chain;
   logic [VALUE_W-1:0]  read_or;
   logic [POS_W-1:0]    found_or;

   assign req_fire = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_if.ready = 1'b0;
      upd_fire     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_if.ready = !reset;
         end
         S_UPDATE: begin
            upd_fire = out_free;
         end
         default: begin
            req_if.ready = 1'b0;
         end
      endcase
   end

   assign csr_if.ready = !reset;

   // slot row
   assign chain[0] = 1'b0;
   assign found    = chain[DEPTH];

   always_comb begin
      cell_ctrl.cmp_en = req_fire;
      cell_ctrl.upd_en = upd_fire;
      cell_ctrl.mode   = mode;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VALUE_W-1:0] left_data;
      logic [VALUE_W-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_mid_l
         assign left_data = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_mid_r
         assign right_data = cell_data[i+1];
      end

      olt_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .cmp_value  (req_if.value),
         .wr_value   (value_ff),
         .pos        (cell_pos),
         .count      (count_ff),
         .left_data  (left_data),
         .right_data (right_data),
         .chain_in   (chain[i]),
         .chain_out  (chain[i+1]),
         .data_out   (cell_data[i]),
         .read_tap   (read_tap[i]),
         .found_tap  (found_tap[i])
      );
   end

   always_comb begin
      read_or  = '0;
      found_or = '0;
      for (int i = 0; i < DEPTH; i++) begin
         read_or  = read_or | read_tap[i];
         found_or = found_or | found_tap[i];
      end
   end

   // operation decode
   assign cnt_ext = CMP_W'(count_ff);
   assign pos_ext = CMP_W'(pos_ff);
   assign is_full = (cnt_ext >= CMP_W'(limit_ff)) || (cnt_ext >= CMP_W'(DEPTH));

   always_comb begin
      status_in = STAT_OK;
      read_in   = '0;
      found_in  = '0;
      mode      = MODE_HOLD;
      cell_pos  = CNT_W'(pos_ext);
      count_in  = count_ff;
      case (op_ff)
         OP_APPEND: begin
            if (is_full) begin
               status_in = STAT_FULL;
            end else begin
               mode     = MODE_OPEN;
               cell_pos = count_ff;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_REMOVE_VALUE: begin
            if (!found) begin
               status_in = STAT_NOT_FOUND;
            end else begin
               mode     = MODE_CLOSE_MATCH;
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_INSERT_AT: begin
            if (is_full) begin
               status_in = STAT_FULL;
            end else if (pos_ext > cnt_ext) begin
               status_in = STAT_BAD_POS;
            end else begin
               mode     = MODE_OPEN;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_REMOVE_AT: begin
            if (pos_ext >= cnt_ext) begin
               status_in = STAT_BAD_POS;
            end else begin
               mode     = MODE_CLOSE_POS;
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_READ_AT: begin
            if (pos_ext >= cnt_ext) begin
               status_in = STAT_BAD_POS;
            end else begin
               read_in = read_or;
            end
         end
         OP_FIND: begin
            if (!found) begin
               status_in = STAT_NOT_FOUND;
            end else begin
               found_in = found_or;
            end
         end
         default: begin
            status_in = STAT_OK;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req_if.operation;
         value_ff <= req_if.value;
         pos_ff   <= req_if.position;
      end
      if (upd_fire) begin
         status_ff <= status_in;
         read_ff   <= read_in;
         found_ff  <= found_in;
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         limit_ff     <= SIZE_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (upd_fire) begin
            count_ff <= count_in;
         end
         if (csr_if.valid) begin
            limit_ff <= csr_if.size_limit;
         end
         if (upd_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.status         = status_ff;
   assign rsp_if.read_value     = read_ff;
   assign rsp_if.found_position = found_ff;
   assign rsp_if.entry_total    = TOTAL_W'(count_ff);

endmodule
